[rtl/iol_pkg.sv]
// ----------------------------------------------------------------------------
// iol_pkg
// shared sizes, operation codes and the control bundle of the ordered list
// ----------------------------------------------------------------------------
package iol_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// fixed field widths of the stream items
	localparam int OP_W  = 3;
	localparam int POS_W = 5;

	// element count holds 0 to CAPACITY
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// compare width wide enough for both a position and a count
	localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int S_TDATA_W = ((DATA_WIDTH + POS_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((DATA_WIDTH + CNT_W + 2 + 7) / 8) * 8;
	localparam int S_TUSER_W = OP_W;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd5;

	// what the cell array does with one item
	typedef struct packed {
		logic            open_gap;  // shift up from at, load word at at
		logic            close_gap; // shift down onto at
		logic [AT_W-1:0] at;
	} cell_ctrl_t;

endpackage

[rtl/iol_decode.sv]
// ----------------------------------------------------------------------------
// iol_decode
// turns an operation and a position into a range-checked cell command
// ----------------------------------------------------------------------------
module iol_decode (
	input  logic [iol_pkg::OP_W-1:0]  operation,
	input  logic [iol_pkg::POS_W-1:0] position,
	input  logic [iol_pkg::CNT_W-1:0] count,
	output iol_pkg::cell_ctrl_t       ctrl
);

	logic [iol_pkg::AT_W-1:0] cnt_w;
	logic [iol_pkg::AT_W-1:0] pos_w;
	logic                     full;
	logic                     empty;

	assign cnt_w = iol_pkg::AT_W'(count);
	assign pos_w = iol_pkg::AT_W'(position);
	assign full  = (cnt_w == iol_pkg::AT_W'(iol_pkg::CAPACITY));
	assign empty = (count == '0);

	always_comb begin
		ctrl.open_gap  = 1'b0;
		ctrl.close_gap = 1'b0;
		ctrl.at        = '0;
		case (operation)
			iol_pkg::OP_PUSH_FRONT: begin
				ctrl.open_gap = !full;
			end
			iol_pkg::OP_PUSH_BACK: begin
				ctrl.at       = cnt_w;
				ctrl.open_gap = !full;
			end
			iol_pkg::OP_INSERT_AT: begin
				ctrl.at       = pos_w;
				ctrl.open_gap = !full && (pos_w <= cnt_w);
			end
			iol_pkg::OP_POP_FRONT: begin
				ctrl.close_gap = !empty;
			end
			iol_pkg::OP_POP_BACK: begin
				ctrl.at        = cnt_w - iol_pkg::AT_W'(1);
				ctrl.close_gap = !empty;
			end
			iol_pkg::OP_REMOVE_AT: begin
				ctrl.at        = pos_w;
				ctrl.close_gap = (pos_w < cnt_w);
			end
			default: begin
				ctrl.at = '0;
			end
		endcase
	end

endmodule

[rtl/iol_store.sv]
// ----------------------------------------------------------------------------
// iol_store
// row of list cells, each holding, shifting up, shifting down or loading
// ----------------------------------------------------------------------------
module iol_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  iol_pkg::cell_ctrl_t            ctrl,
	input  logic [iol_pkg::DATA_WIDTH-1:0] word,
	output logic [iol_pkg::CNT_W-1:0]      count_q,
	output logic [iol_pkg::CNT_W-1:0]      count_next,
	output logic [iol_pkg::DATA_WIDTH-1:0] front_next
);

	logic [iol_pkg::DATA_WIDTH-1:0] cell_q [iol_pkg::CAPACITY];
	logic [iol_pkg::DATA_WIDTH-1:0] cell_d [iol_pkg::CAPACITY];

	always_comb begin
		for (int i = 0; i < iol_pkg::CAPACITY; i++) begin
			cell_d[i] = cell_q[i];
			if (ctrl.open_gap) begin
				if (iol_pkg::AT_W'(i) == ctrl.at)
					cell_d[i] = word;
				else if (i > 0 && iol_pkg::AT_W'(i) > ctrl.at)
					cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
			end else if (ctrl.close_gap) begin
				if (i < iol_pkg::CAPACITY - 1 && iol_pkg::AT_W'(i) >= ctrl.at)
					cell_d[i] = cell_q[(i < iol_pkg::CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.open_gap)
			count_next = count_q + iol_pkg::CNT_W'(1);
		else if (ctrl.close_gap)
			count_next = count_q - iol_pkg::CNT_W'(1);
	end

	assign front_next = (count_next == '0) ? '0 : cell_d[0];

	// cells hold no reset: only entries below the count are ever read
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < iol_pkg::CAPACITY; i++)
				cell_q[i] <= cell_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_next;
		end
	end

endmodule

[rtl/indexed_ordered_list_top.sv]
// ----------------------------------------------------------------------------
// indexed_ordered_list_top
// ordered list of signed words with push, pop, insert and remove by position
// ----------------------------------------------------------------------------
//  channel   dir  item contents
//  s_*       in   tuser: operation; tdata: item_value, position
//  m_*       out  tdata: front_value, element_count, is_empty, applied
//
//  one item per cycle sustained while the result is not stalled; an accepted item
//  passes the input register, then the cell row updates as the result register loads
//  the whole update is one pass through the cell row: every cell shifts up,
//  shifts down, loads or holds in the same cycle
//  reset empties the list at once; cell contents are left as they are
//  a stalled result holds the input register, so s_tready drops only when
//  both the input register and the result register are full
// ----------------------------------------------------------------------------
module indexed_ordered_list_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// operation [2:0]
	input  logic [iol_pkg::S_TUSER_W-1:0] s_tuser,
	// item_value [31:0], position [36:32], zero pad above
	input  logic [iol_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// front_value [31:0], element_count [36:32], is_empty [37], applied [38],
	// zero pad above
	output logic [iol_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int CNT_LO = iol_pkg::DATA_WIDTH;
	localparam int EMP_B  = CNT_LO + iol_pkg::CNT_W;
	localparam int APP_B  = EMP_B + 1;

	// input register
	logic                           valid_s1;
	logic [iol_pkg::OP_W-1:0]       operation_s1;
	logic [iol_pkg::DATA_WIDTH-1:0] item_value_s1;
	logic [iol_pkg::POS_W-1:0]      position_s1;

	// result register
	logic                           valid_s2;
	logic [iol_pkg::DATA_WIDTH-1:0] front_value_s2;
	logic [iol_pkg::CNT_W-1:0]      element_count_s2;
	logic                           applied_s2;

	logic                           advance;
	iol_pkg::cell_ctrl_t            ctrl;
	logic [iol_pkg::CNT_W-1:0]      count_q;
	logic [iol_pkg::CNT_W-1:0]      count_next;
	logic [iol_pkg::DATA_WIDTH-1:0] front_next;

	// the item in the input register moves on when the result slot is free or emptying
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			operation_s1  <= s_tuser[iol_pkg::OP_W-1:0];
			item_value_s1 <= s_tdata[iol_pkg::DATA_WIDTH-1:0];
			position_s1   <= s_tdata[iol_pkg::DATA_WIDTH +: iol_pkg::POS_W];
		end
	end

	iol_decode u_decode (
		.operation (operation_s1),
		.position  (position_s1),
		.count     (count_q),
		.ctrl      (ctrl)
	);

	// the list itself only moves when the item is handed to the result register
	iol_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.ctrl       (ctrl),
		.word       (item_value_s1),
		.count_q    (count_q),
		.count_next (count_next),
		.front_next (front_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			front_value_s2   <= front_next;
			element_count_s2 <= count_next;
			applied_s2       <= ctrl.open_gap || ctrl.close_gap;
		end
	end

	assign m_tvalid = valid_s2;

	always_comb begin
		m_tdata                                 = '0;
		m_tdata[iol_pkg::DATA_WIDTH-1:0]        = front_value_s2;
		m_tdata[CNT_LO +: iol_pkg::CNT_W]       = element_count_s2;
		m_tdata[EMP_B]                          = (element_count_s2 == '0);
		m_tdata[APP_B]                          = applied_s2;
	end

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= iol_pkg::CNT_W'(iol_pkg::CAPACITY))
		else $error("element count above capacity");

	// a pending item that cannot move on stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("pending item lost while result stalled");

	// list length only changes when an item passes through the cell row
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count_q))
		else $error("element count changed without an item");

	// a delivered result reports the count left in the cell row
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (element_count_s2 == count_q))
		else $error("reported count differs from stored count");

	// an empty list never reports a front word
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && element_count_s2 == '0) |-> (front_value_s2 == '0))
		else $error("front word reported on empty list");

endmodule
